[src/sau_pkg.sv]
`timescale 1ns / 1ps

package sau_pkg;

    localparam int unsigned TABLE_SEGMENTS = 64;
    localparam int unsigned IDX_W          = $clog2(TABLE_SEGMENTS + 1);
    localparam int unsigned P_W            = 16 + IDX_W;
    localparam int unsigned TAYLOR_TERMS   = 30;

    localparam logic [15:0] ONE_Q15 = 16'h8000;

    localparam logic FUNC_FWD   = 1'b0;
    localparam logic FUNC_DERIV = 1'b1;

    localparam longint unsigned EXP_NEG1_Q32 = 64'd1580030169;

    typedef logic [TABLE_SEGMENTS:0][15:0] t_knots;

    typedef struct packed {
        logic        func;
        logic [15:0] value;
    } t_item;

    typedef struct packed {
        logic        valid;
        logic        func;
        logic        rise;
        logic [15:0] k0;
        logic [31:0] prod;
    } t_prod;

    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        logic [64:0]     rem;
        longint unsigned quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic longint unsigned exp_neg_q32(input longint unsigned u);
        longint unsigned ipart;
        longint unsigned f;
        longint unsigned term;
        longint          sum;
        longint unsigned e;
        ipart = u >> 32;
        f     = u & 64'hFFFF_FFFF;
        term  = 64'd1 << 32;
        sum   = longint'(64'd1 << 32);
        for (int n = 1; n <= int'(TAYLOR_TERMS); n++) begin
            term = udiv64((term * f) >> 32, longint'(n));
            if (n[0] == 1'b1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        e = longint'(sum);
        for (longint unsigned j = 0; j < ipart; j++) begin
            e = (e * EXP_NEG1_Q32 + (64'd1 << 31)) >> 32;
        end
        return e;
    endfunction

    function automatic t_knots build_knots();
        t_knots          tab;
        longint unsigned seg;
        longint unsigned a;
        longint unsigned b;
        longint unsigned mag;
        longint unsigned u;
        longint unsigned e;
        longint unsigned den;
        longint unsigned num;
        longint unsigned v;
        logic            nonneg;
        seg = longint'(TABLE_SEGMENTS);
        for (longint unsigned k = 0; k <= seg; k++) begin
            a      = 64'd16 * k;
            b      = 64'd8 * seg;
            nonneg = (a >= b);
            mag    = nonneg ? (a - b) : (b - a);
            u      = udiv64(mag << 32, seg);
            e      = exp_neg_q32(u);
            den    = (64'd1 << 32) + e;
            num    = nonneg ? (64'd1 << 47) : (e << 15);
            v      = udiv64(num + (den >> 1), den);
            if (v > 64'd32768) begin
                v = 64'd32768;
            end
            tab[k] = v[15:0];
        end
        return tab;
    endfunction

    localparam t_knots KNOTS = build_knots();

endpackage

[src/sigmoid_activation_unit_top.sv]
`timescale 1ns / 1ps

// Element-wise logistic sigmoid and its derivative for a neural-network layer.
// The input channel carries one element per item: i_s_tdata holds the value
// and i_s_tuser selects the function. With the selector low the value is a
// signed Q4.12 pre-activation and the result is sigmoid(x) in Q1.15, taken
// from a piecewise linear table of knots. With the selector high the value is
// an activation in Q1.15 and the result is a*(1-a) in Q1.15.
// The output channel carries one result item for every input item, in order.
// Items pass in order through stages s1, s2, s3 and the output register.
// One item is accepted per cycle for as long as the receiver keeps
// i_m_tready high; the four register stages and the single 16 x 16
// multiplier that both functions share each handle one item per cycle.
// When the receiver stalls, the whole pipeline holds and a one-item skid
// register on the input takes the item that arrives in that cycle; o_s_tready
// then drops until the pipeline moves again. No item is lost or repeated.
// The synchronous reset empties the pipeline and the skid register. The knot
// table is constant logic and needs no loading after reset.

module sigmoid_activation_unit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // value[15:0]
    input  logic        i_s_tuser,  // func[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata   // result[15:0]
);

    logic           en;
    logic           pipe_v;
    sau_pkg::t_item in_item;
    sau_pkg::t_item pipe_item;
    sau_pkg::t_prod prod;

    logic [32:0]    rnd_fwd;
    logic [32:0]    rnd_der;
    logic [16:0]    d;
    logic [17:0]    y;
    logic [15:0]    n_out;

    logic           r_out_v;
    logic [15:0]    r_out_data;

    assign en      = ~r_out_v | i_m_tready;
    assign in_item = '{func: i_s_tuser, value: i_s_tdata};

    sau_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_item  (in_item),
        .o_ready (o_s_tready),
        .i_en    (en),
        .o_valid (pipe_v),
        .o_item  (pipe_item)
    );

    sau_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (pipe_v),
        .i_item  (pipe_item),
        .o_prod  (prod)
    );

    assign rnd_fwd = 33'(prod.prod) + 33'd32768;
    assign rnd_der = 33'(prod.prod) + 33'd16384;
    assign d       = rnd_fwd[32:16];

    always_comb begin
        if (prod.rise) begin
            y = 18'(prod.k0) + 18'(d);
        end else if (d > 17'(prod.k0)) begin
            y = '0;
        end else begin
            y = 18'(prod.k0) - 18'(d);
        end
        if (prod.func == sau_pkg::FUNC_DERIV) begin
            n_out = rnd_der[30:15];
        end else if (y > 18'(sau_pkg::ONE_Q15)) begin
            n_out = sau_pkg::ONE_Q15;
        end else begin
            n_out = y[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= prod.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && prod.valid) begin
            r_out_data <= n_out;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;

endmodule

[src/sau_skid.sv]
`timescale 1ns / 1ps

module sau_skid (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  sau_pkg::t_item i_item,
    output logic          o_ready,
    input  logic          i_en,
    output logic          o_valid,
    output sau_pkg::t_item o_item
);

    logic           r_sk_v;
    logic           n_sk_v;
    sau_pkg::t_item r_sk_item;

    assign o_ready = ~r_sk_v;
    assign o_valid = r_sk_v | i_valid;
    assign o_item  = r_sk_v ? r_sk_item : i_item;

    always_comb begin
        n_sk_v = r_sk_v;
        if (i_en) begin
            n_sk_v = 1'b0;
        end else if (i_valid && !r_sk_v) begin
            n_sk_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_v <= 1'b0;
        end else begin
            r_sk_v <= n_sk_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_en && i_valid && !r_sk_v) begin
            r_sk_item <= i_item;
        end
    end

endmodule

[src/sau_pipe.sv]
`timescale 1ns / 1ps

module sau_pipe (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  sau_pkg::t_item i_item,
    output sau_pkg::t_prod o_prod
);

    logic [15:0]                  biased;
    logic [sau_pkg::P_W-1:0]      p;
    logic [sau_pkg::IDX_W-1:0]    idx;
    logic [15:0]                  a_c;

    logic                         r_s1_v;
    logic                         r_s1_func;
    logic [sau_pkg::IDX_W-1:0]    r_s1_idx;
    logic [15:0]                  r_s1_fr;
    logic [15:0]                  r_s1_da;
    logic [15:0]                  r_s1_db;

    logic [sau_pkg::IDX_W-1:0]    idx_nx;
    logic [15:0]                  k0;
    logic [15:0]                  k1;
    logic                         rise;
    logic [15:0]                  diff;

    logic                         r_s2_v;
    logic                         r_s2_func;
    logic                         r_s2_rise;
    logic [15:0]                  r_s2_k0;
    logic [15:0]                  r_s2_ma;
    logic [15:0]                  r_s2_mb;

    logic                         r_s3_v;
    logic                         r_s3_func;
    logic                         r_s3_rise;
    logic [15:0]                  r_s3_k0;
    logic [31:0]                  r_s3_prod;

    assign biased = {~i_item.value[15], i_item.value[14:0]};
    assign p      = sau_pkg::P_W'(biased) * sau_pkg::P_W'(sau_pkg::TABLE_SEGMENTS);

    always_comb begin
        idx = p[sau_pkg::P_W-1:16];
        if (idx > sau_pkg::IDX_W'(sau_pkg::TABLE_SEGMENTS - 1)) begin
            idx = sau_pkg::IDX_W'(sau_pkg::TABLE_SEGMENTS - 1);
        end
        a_c = (i_item.value > sau_pkg::ONE_Q15) ? sau_pkg::ONE_Q15 : i_item.value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_en) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_func <= i_item.func;
            r_s1_idx  <= idx;
            r_s1_fr   <= p[15:0];
            r_s1_da   <= a_c;
            r_s1_db   <= sau_pkg::ONE_Q15 - a_c;
        end
    end

    assign idx_nx = r_s1_idx + 1'b1;
    assign k0     = sau_pkg::KNOTS[r_s1_idx];
    assign k1     = sau_pkg::KNOTS[idx_nx];
    assign rise   = (k1 >= k0);
    assign diff   = rise ? (k1 - k0) : (k0 - k1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (i_en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_func <= r_s1_func;
            r_s2_rise <= rise;
            r_s2_k0   <= k0;
            if (r_s1_func == sau_pkg::FUNC_DERIV) begin
                r_s2_ma <= r_s1_da;
                r_s2_mb <= r_s1_db;
            end else begin
                r_s2_ma <= diff;
                r_s2_mb <= r_s1_fr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (i_en) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_func <= r_s2_func;
            r_s3_rise <= r_s2_rise;
            r_s3_k0   <= r_s2_k0;
            r_s3_prod <= 32'(r_s2_ma) * 32'(r_s2_mb);
        end
    end

    assign o_prod = '{valid: r_s3_v, func: r_s3_func, rise: r_s3_rise,
                      k0: r_s3_k0, prod: r_s3_prod};

endmodule

[src/sau_checker.sv]
`timescale 1ns / 1ps

module sau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("Output item dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("Output data changed while stalled.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("Output valid right after reset.");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata <= 16'h8000)
        else $error("Result above one.");

    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> $past(o_m_tvalid && !i_m_tready))
        else $error("Input ready dropped without an output stall.");

endmodule

bind sigmoid_activation_unit_top sau_checker u_sau_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
